[hdl/tbg_pkg.sv]
// Shared constants, types and codes of the tone burst generator.
`default_nettype none

package tbg_pkg;

	localparam int unsigned SAMPLE_RATE_DEFAULT = 16000;

	// widths of the item fields
	localparam int unsigned FIELD_W  = 16;
	localparam int unsigned KIND_W   = 3;
	localparam int unsigned SAMPLE_W = 15;
	localparam int unsigned MAG_W    = 14;

	localparam int unsigned FIELD_MAX = 65535;
	localparam int unsigned AMPLITUDE = 16000;
	localparam int unsigned MS_PER_S  = 1000;
	localparam int unsigned CHUNKS_PER_S = 10;

	// reciprocal of 1000, exact for dividends below 2^26
	localparam int unsigned    RECIP_SHIFT = 36;
	localparam longint unsigned RECIP_MS   =
		((64'd1 << RECIP_SHIFT) + 64'(MS_PER_S) - 64'd1) / 64'(MS_PER_S);

	// pi/2 in Q62 and the Taylor divisors (2k)(2k+1) of the sine series
	localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;
	localparam int unsigned TAYLOR_TERMS = 13;
	localparam longint unsigned TAYLOR_DIV [TAYLOR_TERMS] =
		'{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210,
		  64'd272, 64'd342, 64'd420, 64'd506, 64'd600, 64'd702};

	localparam logic CMD_START = 1'b0;
	localparam logic CMD_TICK  = 1'b1;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_IDLE,
		KIND_TONE,
		KIND_GAP,
		KIND_STARTED,
		KIND_IGNORED
	} kind_t;

	// what the sequencer reports for one accepted word
	typedef struct packed {
		kind_t kind;
		logic  last;
		logic  tone;
	} seq_result_t;

endpackage

`default_nettype wire

[hdl/tbg_ctrl_if.sv]
// Command channel: start and tick words with their handshake.
`default_nettype none

interface tbg_ctrl_if;

	logic                          valid;
	logic                          ready;
	logic                          cmd;
	logic [tbg_pkg::FIELD_W-1:0]   tone_freq;
	logic [tbg_pkg::FIELD_W-1:0]   tone_ms;
	logic [tbg_pkg::FIELD_W-1:0]   pause_ms;
	logic [tbg_pkg::FIELD_W-1:0]   repeat_count;

	modport source (
		output valid, cmd, tone_freq, tone_ms, pause_ms, repeat_count,
		input  ready
	);

	modport sink (
		input  valid, cmd, tone_freq, tone_ms, pause_ms, repeat_count,
		output ready
	);

endinterface

`default_nettype wire

[hdl/tbg_audio_if.sv]
// Result channel: one sample word per command word.
`default_nettype none

interface tbg_audio_if;

	logic                        valid;
	logic                        ready;
	tbg_pkg::sample_t            sample;
	logic [tbg_pkg::KIND_W-1:0]  kind;
	logic                        last;

	modport source (
		output valid, sample, kind, last,
		input  ready
	);

	modport sink (
		input  valid, sample, kind, last,
		output ready
	);

endinterface

`default_nettype wire

[hdl/tbg_sine_rom.sv]
// Full-wave sine ROM with registered read, built at elaboration in exact fixed point.
`default_nettype none

module tbg_sine_rom #(
	parameter int unsigned SAMPLE_RATE_HZ = tbg_pkg::SAMPLE_RATE_DEFAULT,
	parameter int unsigned PH_W           = $clog2(SAMPLE_RATE_HZ)
) (
	input  wire logic              clk,
	input  wire logic              rd_en,
	input  wire logic [PH_W-1:0]   addr,
	output tbg_pkg::sample_t       data
);

	localparam int unsigned SR = SAMPLE_RATE_HZ;

	function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] prod;
		prod = {64'd0, a} * {64'd0, b};
		return prod[125:62];
	endfunction

	// floor(AMPLITUDE * sin((pi/2) * num / SR)), num in [0, SR]
	function automatic logic [tbg_pkg::MAG_W-1:0] quarter_sine(input logic [31:0] num);
		logic [63:0] wide, hi, rem, f, x, x2, term, sum, sh, sl, val;
		if (num == 32'd0)
			return '0;
		if (num >= SR)
			return tbg_pkg::MAG_W'(tbg_pkg::AMPLITUDE);
		if (3 * num == SR)
			return tbg_pkg::MAG_W'(tbg_pkg::AMPLITUDE / 2);
		wide = {num, 32'd0};
		hi   = wide / SR;
		rem  = wide % SR;
		f    = (hi << 30) + ((rem << 30) / SR);
		x    = mul_q62(tbg_pkg::HALF_PI_Q62, f);
		x2   = mul_q62(x, x);
		term = x;
		sum  = x;
		for (int k = 1; k <= tbg_pkg::TAYLOR_TERMS; k++) begin
			term = mul_q62(term, x2) / tbg_pkg::TAYLOR_DIV[k-1];
			if (k[0])
				sum = sum - term;
			else
				sum = sum + term;
		end
		sh  = sum >> 31;
		sl  = {33'd0, sum[30:0]};
		val = (64'(tbg_pkg::AMPLITUDE) * sh + ((64'(tbg_pkg::AMPLITUDE) * sl) >> 31)) >> 31;
		if (val > 64'(tbg_pkg::AMPLITUDE))
			val = 64'(tbg_pkg::AMPLITUDE);
		return tbg_pkg::MAG_W'(val);
	endfunction

	// signed sample at phase p, folded onto the quarter wave
	function automatic tbg_pkg::sample_t sine_at(input int unsigned p);
		logic [31:0]                u;
		logic [tbg_pkg::MAG_W-1:0] mag;
		logic                       neg;
		u = 32'(4 * p);
		if (u <= SR) begin
			mag = quarter_sine(u);
			neg = 1'b0;
		end else if (u <= 2 * SR) begin
			mag = quarter_sine(32'(2 * SR) - u);
			neg = 1'b0;
		end else if (u <= 3 * SR) begin
			mag = quarter_sine(u - 32'(2 * SR));
			neg = 1'b1;
		end else begin
			mag = quarter_sine(32'(4 * SR) - u);
			neg = 1'b1;
		end
		return neg ? -tbg_pkg::sample_t'({1'b0, mag}) : tbg_pkg::sample_t'({1'b0, mag});
	endfunction

	tbg_pkg::sample_t tab [SR];
	tbg_pkg::sample_t data_q;

	for (genvar i = 0; i < SR; i++) begin : g_tab
		localparam tbg_pkg::sample_t VAL = sine_at(i);
		assign tab[i] = VAL;
	end

	always_ff @(posedge clk) begin
		if (rd_en)
			data_q <= tab[addr];
	end

	assign data = data_q;

endmodule

`default_nettype wire

[hdl/tbg_sequencer.sv]
// Burst sequencer: start decode, segment and repeat counting, phase accumulation.
`default_nettype none

module tbg_sequencer #(
	parameter int unsigned SAMPLE_RATE_HZ = tbg_pkg::SAMPLE_RATE_DEFAULT,
	parameter int unsigned PH_W           = $clog2(SAMPLE_RATE_HZ)
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          acc,
	input  wire logic                          cmd,
	input  wire logic [tbg_pkg::FIELD_W-1:0]   tone_freq,
	input  wire logic [tbg_pkg::FIELD_W-1:0]   tone_ms,
	input  wire logic [tbg_pkg::FIELD_W-1:0]   pause_ms,
	input  wire logic [tbg_pkg::FIELD_W-1:0]   repeat_count,
	output tbg_pkg::seq_result_t               res,
	output logic                               rom_rd,
	output logic [PH_W-1:0]                    rom_addr
);

	localparam int unsigned SR       = SAMPLE_RATE_HZ;
	localparam int unsigned CHUNK    = SR / tbg_pkg::CHUNKS_PER_S;
	localparam int unsigned CH_W     = $clog2(CHUNK);
	localparam longint unsigned LEN_MAX =
		(64'(tbg_pkg::FIELD_MAX) * 64'(SR)) / 64'(tbg_pkg::MS_PER_S);
	localparam int unsigned LEN_W    = $clog2(LEN_MAX + 64'd1);
	localparam int unsigned RATE_K   = SR / tbg_pkg::MS_PER_S;
	localparam int unsigned RATE_R   = SR % tbg_pkg::MS_PER_S;
	localparam int unsigned FOLD_MAX = tbg_pkg::FIELD_MAX / SR;
	localparam int unsigned FW       = tbg_pkg::FIELD_W;

	// ms * SR / 1000 as ms * (SR / 1000) plus a reciprocal product for the remainder
	function automatic logic [LEN_W-1:0] ms_to_len(input logic [FW-1:0] ms);
		logic [25:0] part;
		logic [52:0] prod;
		part = 26'(ms * RATE_R);
		prod = 53'(part) * 53'(tbg_pkg::RECIP_MS);
		return LEN_W'(ms * RATE_K) + LEN_W'(prod[52:tbg_pkg::RECIP_SHIFT]);
	endfunction

	logic               busy_q,    busy_n;
	logic [PH_W-1:0]    step_q,    step_n;
	logic [PH_W-1:0]    phase_q,   phase_n;
	logic [CH_W-1:0]    chunk_q,   chunk_n;
	logic [LEN_W-1:0]   seg_q,     seg_n;
	logic               gap_q,     gap_n;
	logic [FW-1:0]      reps_q,    reps_n;
	logic [LEN_W-1:0]   tone_len_q, tone_len_n;
	logic [LEN_W-1:0]   gap_len_q,  gap_len_n;

	logic [LEN_W-1:0]   tl, gl;
	logic [PH_W-1:0]    step_mod;
	logic [PH_W:0]      phase_sum;
	logic [CH_W:0]      chunk_inc;
	logic [LEN_W-1:0]   seg_dec;
	logic               playable;

	assign tl = ms_to_len(tone_ms);
	assign gl = ms_to_len(pause_ms);
	assign playable = (repeat_count != '0) &&
		((tl != '0) || ((repeat_count > FW'(1)) && (gl != '0)));

	// frequency modulo the rate: pick the largest multiple that fits
	always_comb begin
		step_mod = '0;
		for (int k = 0; k <= FOLD_MAX; k++) begin
			if ({1'b0, tone_freq} >= 17'(k * SR))
				step_mod = PH_W'({1'b0, tone_freq} - 17'(k * SR));
		end
	end

	assign phase_sum = {1'b0, phase_q} + {1'b0, step_q};
	assign chunk_inc = {1'b0, chunk_q} + (CH_W + 1)'(1);
	assign seg_dec   = seg_q - LEN_W'(1);

	always_comb begin
		busy_n     = busy_q;
		step_n     = step_q;
		phase_n    = phase_q;
		chunk_n    = chunk_q;
		seg_n      = seg_q;
		gap_n      = gap_q;
		reps_n     = reps_q;
		tone_len_n = tone_len_q;
		gap_len_n  = gap_len_q;
		res.kind   = tbg_pkg::KIND_IDLE;
		res.last   = 1'b0;
		res.tone   = 1'b0;

		if (cmd == tbg_pkg::CMD_START) begin
			if (busy_q || !playable) begin
				res.kind = tbg_pkg::KIND_IGNORED;
			end else begin
				res.kind   = tbg_pkg::KIND_STARTED;
				busy_n     = 1'b1;
				step_n     = step_mod;
				tone_len_n = tl;
				gap_len_n  = gl;
				reps_n     = repeat_count - FW'(1);
				chunk_n    = '0;
				phase_n    = '0;
				// an empty burst goes straight to its gap
				if (tl != '0) begin
					gap_n = 1'b0;
					seg_n = tl;
				end else begin
					gap_n = 1'b1;
					seg_n = gl;
				end
			end
		end else if (busy_q) begin
			if (gap_q) begin
				res.kind = tbg_pkg::KIND_GAP;
			end else begin
				res.kind = tbg_pkg::KIND_TONE;
				res.tone = 1'b1;
				if (phase_sum >= (PH_W + 1)'(SR))
					phase_n = PH_W'(phase_sum - (PH_W + 1)'(SR));
				else
					phase_n = phase_sum[PH_W-1:0];
				if (chunk_inc >= (CH_W + 1)'(CHUNK)) begin
					chunk_n = '0;
					phase_n = '0;
				end else begin
					chunk_n = chunk_inc[CH_W-1:0];
				end
			end
			seg_n = seg_dec;

			if (seg_dec == '0) begin
				if (!gap_q) begin
					// burst ended
					if (reps_q == '0) begin
						busy_n   = 1'b0;
						res.last = 1'b1;
					end else if (gap_len_q != '0) begin
						gap_n = 1'b1;
						seg_n = gap_len_q;
					end else begin
						reps_n  = reps_q - FW'(1);
						gap_n   = 1'b0;
						chunk_n = '0;
						phase_n = '0;
						seg_n   = tone_len_q;
					end
				end else begin
					// gap ended
					if (reps_q == '0) begin
						busy_n   = 1'b0;
						res.last = 1'b1;
					end else begin
						reps_n  = reps_q - FW'(1);
						chunk_n = '0;
						phase_n = '0;
						if (tone_len_q != '0) begin
							gap_n = 1'b0;
							seg_n = tone_len_q;
						end else if (reps_q == FW'(1)) begin
							busy_n   = 1'b0;
							res.last = 1'b1;
						end else begin
							gap_n = 1'b1;
							seg_n = gap_len_q;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			step_q     <= '0;
			phase_q    <= '0;
			chunk_q    <= '0;
			seg_q      <= '0;
			gap_q      <= 1'b0;
			reps_q     <= '0;
			tone_len_q <= '0;
			gap_len_q  <= '0;
		end else if (acc) begin
			busy_q     <= busy_n;
			step_q     <= step_n;
			phase_q    <= phase_n;
			chunk_q    <= chunk_n;
			seg_q      <= seg_n;
			gap_q      <= gap_n;
			reps_q     <= reps_n;
			tone_len_q <= tone_len_n;
			gap_len_q  <= gap_len_n;
		end
	end

	// look up the sample of the current phase
	assign rom_rd   = acc && res.tone;
	assign rom_addr = phase_q;

	a_last_ends_sequence: assert property (@(posedge clk) disable iff (!arst_n)
		acc && res.last |=> !busy_q)
		else $error("sequencer still busy after the last sample");

	a_start_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		acc && (cmd == tbg_pkg::CMD_START) && busy_q |-> res.kind == tbg_pkg::KIND_IGNORED)
		else $error("start accepted while a sequence plays");

	a_phase_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (32'(phase_q) < SR) && (32'(step_q) < SR) && (seg_q != '0))
		else $error("phase, step or segment count out of range while busy");

endmodule

`default_nettype wire

[hdl/tone_burst_generator.sv]
// Tone burst generator: beep sequencer with a sine ROM and a registered output word.
//
// Channels: ctrl (sink) takes command words; cmd selects start or sample tick. A start
// word loads frequency, tone length, pause length and repeat count; a tick word asks
// for the next sample. audio (source) returns exactly one word per command word:
// the signed sample, its kind (idle, tone, gap, start accepted, start ignored) and a
// last flag on the final sample of a sequence.
//
// Timing: the audio word of an accepted command word appears in the cycle after, from the
// output register and the registered read of the sine ROM, which holds SAMPLE_RATE_HZ entries of 15 bits.
// Throughput: one word per cycle while audio.ready is high; a word may then be accepted in every cycle.
//
// Reset: the sequencer goes idle and the output register empties; ticks then give
// idle words until a start arrives.
// Stall: while an audio word waits unaccepted, ctrl.ready follows audio.ready, so a
// new command word is taken in the very cycle the waiting word leaves.
`default_nettype none

module tone_burst_generator #(
	parameter int unsigned SAMPLE_RATE_HZ = tbg_pkg::SAMPLE_RATE_DEFAULT
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	tbg_ctrl_if.sink             ctrl,
	tbg_audio_if.source          audio
);

	localparam int unsigned PH_W = $clog2(SAMPLE_RATE_HZ);

	logic                  adv;
	logic                  acc;
	tbg_pkg::seq_result_t  res;
	logic                  rom_rd;
	logic [PH_W-1:0]       rom_addr;
	tbg_pkg::sample_t      rom_data;

	logic                  valid_s1;
	tbg_pkg::seq_result_t  res_s1;

	// move when the output register is empty or being drained
	assign adv        = !valid_s1 || audio.ready;
	assign ctrl.ready = adv;
	assign acc        = ctrl.valid && adv;

	tbg_sequencer #(
		.SAMPLE_RATE_HZ (SAMPLE_RATE_HZ),
		.PH_W           (PH_W)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.acc          (acc),
		.cmd          (ctrl.cmd),
		.tone_freq    (ctrl.tone_freq),
		.tone_ms      (ctrl.tone_ms),
		.pause_ms     (ctrl.pause_ms),
		.repeat_count (ctrl.repeat_count),
		.res          (res),
		.rom_rd       (rom_rd),
		.rom_addr     (rom_addr)
	);

	tbg_sine_rom #(
		.SAMPLE_RATE_HZ (SAMPLE_RATE_HZ),
		.PH_W           (PH_W)
	) u_rom (
		.clk   (clk),
		.rd_en (rom_rd),
		.addr  (rom_addr),
		.data  (rom_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= acc;
		end
	end

	always_ff @(posedge clk) begin
		if (adv)
			res_s1 <= res;
	end

	assign audio.valid  = valid_s1;
	assign audio.sample = res_s1.tone ? rom_data : '0;
	assign audio.kind   = res_s1.kind;
	assign audio.last   = res_s1.last;

	a_silent_unless_tone: assert property (@(posedge clk) disable iff (!arst_n)
		audio.valid && (audio.kind != tbg_pkg::KIND_TONE) |-> audio.sample == '0)
		else $error("non-tone word carries a sample");

	a_last_on_samples: assert property (@(posedge clk) disable iff (!arst_n)
		audio.valid && audio.last |->
			(audio.kind == tbg_pkg::KIND_TONE) || (audio.kind == tbg_pkg::KIND_GAP))
		else $error("last flag on a word that is no sample");

	a_accept_fills_output: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> valid_s1)
		else $error("accepted word produced no output word");

endmodule

`default_nettype wire
